>>> rtl/running_average_background_subtract_defines.svh
// Assertion macros shared by the running-average background subtraction RTL.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACT_DEFINES_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RABS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define RABS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rabs_pkg.sv
// Package with widths, constants and register codes of the background subtractor.
package rabs_pkg;

    // Store depth and fixed-point format
    localparam int MAX_SAMPLES = 262144;
    localparam int FRAC_W      = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int PIX_W       = 8;
    localparam int BG_W        = PIX_W + FRAC_W;
    localparam int ALPHA_W     = FRAC_W + 1;
    localparam int FRAME_W     = 19;
    localparam int DIFF_W      = BG_W + 1;
    localparam int PROD_W      = DIFF_W + ALPHA_W + 1;
    localparam int STEP_W      = PROD_W - FRAC_W;
    localparam int SUM_W       = BG_W + 4;
    localparam int CFG_DATA_W  = (ALPHA_W > FRAME_W) ? ALPHA_W : FRAME_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = ALPHA_W'(1) << FRAC_W;
    localparam logic [FRAME_W-1:0] FRAME_MAX    = FRAME_W'(MAX_SAMPLES);
    localparam logic [FRAME_W-1:0] FRAME_RESET  = FRAME_W'(230400);
    localparam logic [BG_W-1:0]    BG_MAX       = '1;
    localparam logic [FRAC_W-1:0]  FRAC_HALF    = FRAC_W'(1) << (FRAC_W - 1);
    localparam logic [PIX_W:0]     PIX_MAX      = (PIX_W + 1)'((1 << PIX_W) - 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_ALPHA = 1'b0,
        CFG_FRAME = 1'b1
    } t_cfg_index;

endpackage

>>> rtl/running_average_background_subtract.sv
// Top level: running-average background subtraction over a stream of 8-bit samples.
// One item per clock while neither output back-pressure nor a store hazard holds it;
// each item passes through read, multiply and update/round into the output register.
// The background sits in a 262144 x 24-bit memory with one read and one write port;
// an item whose store entry is still in flight (frames of one or two samples) waits
// for the write-back. The store is not cleared; the first frame writes its entries.
`include "running_average_background_subtract_defines.svh"

module running_average_background_subtract import rabs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] sample
    // Output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [7:0] difference
    output logic                  o_m_axis_tlast    // frame_end
);

    // Configuration and frame state
    logic [ALPHA_W-1:0] r_alpha;
    logic [FRAME_W-1:0] r_frame;
    logic [ADDR_W-1:0]  r_position, n_position;
    logic               r_bg_valid;

    // Stage 1: memory read data present
    logic               r_s1_valid;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [PIX_W-1:0]   r_s1_pix;
    logic               r_s1_first;
    logic               r_s1_last;
    logic [ALPHA_W-1:0] r_s1_alpha;
    logic [BG_W-1:0]    r_rd;

    // Stage 2: product present
    logic               r_s2_valid;
    logic [ADDR_W-1:0]  r_s2_addr;
    logic [PIX_W-1:0]   r_s2_pix;
    logic               r_s2_first;
    logic               r_s2_last;
    logic [BG_W-1:0]    r_s2_bg;
    logic signed [PROD_W-1:0] r_s2_prod;

    // Output register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_diff;
    logic               r_out_last;

    logic [BG_W-1:0]    r_mem [MAX_SAMPLES];

    logic               advance;
    logic               hazard;
    logic               accept;
    logic [ALPHA_W-1:0] alpha_sat;
    logic [FRAME_W-1:0] size_sat;
    logic [ADDR_W-1:0]  size_m1;
    logic               last;

    logic signed [DIFF_W-1:0]  s1_diff;
    logic signed [PROD_W-1:0]  s1_prod;
    logic signed [STEP_W-1:0]  s2_step;
    logic signed [SUM_W-1:0]   s2_sum;
    logic [BG_W-1:0]           s2_bg_new;
    logic [PIX_W:0]            s2_round;
    logic [PIX_W-1:0]          s2_ip;
    logic [FRAC_W-1:0]         s2_frac;
    logic [PIX_W-1:0]          s2_bg_pix;
    logic [PIX_W-1:0]          s2_diff;

    // Pipeline moves whenever the output register can take an item
    assign advance = !r_out_valid || i_m_axis_tready;

    // Hold an item whose entry is still being updated further down
    assign hazard = (r_s1_valid && (r_s1_addr == r_position))
                 || (r_s2_valid && (r_s2_addr == r_position));

    assign o_s_axis_tready = advance && !hazard;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Clamp configuration into range
    always_comb begin
        alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        if (r_frame == '0) begin
            size_sat = FRAME_W'(1);
        end else if (r_frame > FRAME_MAX) begin
            size_sat = FRAME_MAX;
        end else begin
            size_sat = r_frame;
        end
        size_m1    = ADDR_W'(size_sat - FRAME_W'(1));
        last       = (r_position >= size_m1);
        n_position = last ? '0 : r_position + ADDR_W'(1);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
            r_frame <= FRAME_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_FRAME: r_frame <= i_cfg_data[FRAME_W-1:0];
                default:   r_alpha <= r_alpha;
            endcase
        end
    end

    // Advance frame position on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_bg_valid <= 1'b0;
        end else if (accept) begin
            r_position <= n_position;
            if (last) begin
                r_bg_valid <= 1'b1;
            end
        end
    end

    // Background memory: read on accept, write back from stage 2
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[r_position];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid) begin
            r_mem[r_s2_addr] <= s2_bg_new;
        end
    end

    // Stage 1: difference to target and weighted step
    always_comb begin
        s1_diff = $signed({1'b0, r_s1_pix, FRAC_W'(0)}) - $signed({1'b0, r_rd});
        s1_prod = PROD_W'(s1_diff) * PROD_W'($signed({1'b0, r_s1_alpha}));
    end

    // Stage 2: update, clamp, round and subtract
    always_comb begin
        s2_step = r_s2_prod[PROD_W-1:FRAC_W];
        s2_sum  = $signed({4'b0, r_s2_bg}) + SUM_W'(s2_step);
        if (r_s2_first) begin
            s2_bg_new = {r_s2_pix, FRAC_W'(0)};
        end else if (s2_sum < 0) begin
            s2_bg_new = '0;
        end else if (s2_sum > $signed({4'b0, BG_MAX})) begin
            s2_bg_new = BG_MAX;
        end else begin
            s2_bg_new = s2_sum[BG_W-1:0];
        end
        s2_ip   = s2_bg_new[BG_W-1:FRAC_W];
        s2_frac = s2_bg_new[FRAC_W-1:0];
        if ((s2_frac > FRAC_HALF) || ((s2_frac == FRAC_HALF) && s2_ip[0])) begin
            s2_round = {1'b0, s2_ip} + (PIX_W + 1)'(1);
        end else begin
            s2_round = {1'b0, s2_ip};
        end
        s2_bg_pix = (s2_round > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : s2_round[PIX_W-1:0];
        if (r_s2_first || (r_s2_pix <= s2_bg_pix)) begin
            s2_diff = '0;
        end else begin
            s2_diff = r_s2_pix - s2_bg_pix;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_addr  <= r_position;
            r_s1_pix   <= i_s_axis_tdata[PIX_W-1:0];
            r_s1_first <= !r_bg_valid;
            r_s1_last  <= last;
            r_s1_alpha <= alpha_sat;

            r_s2_addr  <= r_s1_addr;
            r_s2_pix   <= r_s1_pix;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_bg    <= r_rd;
            r_s2_prod  <= s1_prod;

            r_out_diff <= s2_diff;
            r_out_last <= r_s2_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_diff;
    assign o_m_axis_tlast  = r_out_last;

    // Checks
    `RABS_ASSERT_SAME(a_no_overlap, r_s1_valid && r_s2_valid, r_s1_addr != r_s2_addr, "two in-flight items share a store entry")
    `RABS_ASSERT_NEXT(a_wrap, accept && last, r_position == '0, "position did not wrap after the last item of a frame")
    `RABS_ASSERT_NEXT(a_bg_sticky, r_bg_valid, r_bg_valid, "background valid flag dropped")

endmodule

>>> sim/running_average_background_subtract_tb.sv
// Testbench for the running-average background subtractor: stream stimulus and result check.
module running_average_background_subtract_tb;
    import rabs_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] difference;
        logic             frame_end;
    } t_diff_item;

    // Clock, reset and block ports
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [7:0]            o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // Background model: store, frame position and register copies
    logic [BG_W-1:0]    bg_store [MAX_SAMPLES];
    logic               bg_valid;
    int                 next_pos;
    int                 written_entries;
    logic [ALPHA_W-1:0] model_alpha;
    logic [FRAME_W-1:0] model_frame;

    // Expected results, idling and bookkeeping
    t_diff_item expected_diffs[$];
    int         send_idle_pct = 22;
    int         recv_idle_pct = 71;
    int         stall_hold;
    int         errors;
    int         samples_sent;
    int         results_checked;
    int         frame_ends;
    int         input_stall_cycles;

    running_average_background_subtract dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),        // [7:0] sample
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata), // [7:0] difference
        .o_m_axis_tlast  (o_m_axis_tlast)  // frame_end
    );

    always #4 i_clk = ~i_clk;

    // Compute the difference and frame end for one accepted sample, advance the model
    task automatic predict_difference(input logic [PIX_W-1:0] value);
        t_diff_item         item;
        int                 size;
        int                 idx;
        logic [ALPHA_W-1:0] weight;
        logic [BG_W-1:0]    bg;
        longint             prod;
        longint             nb;
        logic [PIX_W:0]     whole;
        size = (model_frame == 0) ? 1 :
               (model_frame > MAX_SAMPLES) ? MAX_SAMPLES : int'(model_frame);
        weight = (model_alpha > ALPHA_ONE) ? ALPHA_ONE : model_alpha;
        idx = next_pos % MAX_SAMPLES;
        item.frame_end  = (next_pos >= size - 1);
        item.difference = '0;
        if (!bg_valid) begin
            // First frame: take the sample as background
            bg_store[idx] = {value, {FRAC_W{1'b0}}};
            if (idx + 1 > written_entries)
                written_entries = idx + 1;
        end else begin
            if (weight != 0) begin
                prod = (longint'({value, {FRAC_W{1'b0}}}) - longint'(bg_store[idx]))
                       * longint'(weight);
                nb = longint'(bg_store[idx]) + (prod >>> FRAC_W);
                if (nb < 0)
                    nb = 0;
                if (nb > longint'(BG_MAX))
                    nb = longint'(BG_MAX);
                bg_store[idx] = nb[BG_W-1:0];
            end
            // Round half to even, then subtract with a floor at zero
            bg    = bg_store[idx];
            whole = {1'b0, bg[BG_W-1:FRAC_W]};
            if (bg[FRAC_W-1:0] > FRAC_HALF || (bg[FRAC_W-1:0] == FRAC_HALF && bg[FRAC_W]))
                whole = whole + (PIX_W + 1)'(1);
            if (whole > PIX_MAX)
                whole = PIX_MAX;
            if ({1'b0, value} > whole)
                item.difference = value - whole[PIX_W-1:0];
        end
        if (item.frame_end) begin
            next_pos = 0;
            bg_valid = 1'b1;
        end else begin
            next_pos = next_pos + 1;
        end
        expected_diffs.push_back(item);
    endtask

    // Offer one sample, idling at random first, and hold it until accepted
    task automatic send_sample(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        samples_sent++;
        predict_difference(value);
    endtask

    function automatic logic [PIX_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Drain the block, then write both registers back to back
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] alpha_value,
                                  input logic [CFG_DATA_W-1:0] frame_value);
        s_tvalid <= 1'b0;
        while (expected_diffs.size() != 0)
            @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ALPHA;
        cfg_data  <= alpha_value;
        @(posedge i_clk);
        cfg_index <= CFG_FRAME;
        cfg_data  <= frame_value;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        model_alpha = alpha_value[ALPHA_W-1:0];
        model_frame = frame_value[FRAME_W-1:0];
    endtask

    // First frame with an oversized frame register, then cut short past its end
    task automatic test_first_frame();
        logic [PIX_W-1:0] extremes [10];
        extremes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80, 8'h7F, 8'hFE};
        apply_settings('1, '1);
        foreach (extremes[k])
            send_sample(extremes[k]);
        repeat (246)
            send_sample(random_sample());
        apply_settings('1, CFG_DATA_W'(64));
        send_sample(8'h3C);
    endtask

    // Static, tiny, unit, half and above-unit weights over a four-sample frame
    task automatic test_alpha_extremes();
        apply_settings('0, CFG_DATA_W'(4));
        send_sample(8'hFF);
        send_sample(8'h00);
        apply_settings(CFG_DATA_W'(1), CFG_DATA_W'(4));
        send_sample(8'h03);
        send_sample(8'hFC);
        apply_settings(CFG_DATA_W'(ALPHA_ONE), CFG_DATA_W'(4));
        send_sample(8'd17);
        send_sample(8'd200);
        send_sample(8'h00);
        send_sample(8'hFF);
        // Background lands exactly on .5: one tie rounds down, one up
        apply_settings(CFG_DATA_W'(ALPHA_ONE >> 1), CFG_DATA_W'(4));
        send_sample(8'd20);
        send_sample(8'd203);
        apply_settings(CFG_DATA_W'(ALPHA_ONE + 1), CFG_DATA_W'(4));
        send_sample(8'h40);
        send_sample(8'h01);
    endtask

    // Zero-size frame and two-sample frame: back-to-back hits on one store entry
    task automatic test_tiny_frames();
        apply_settings(CFG_DATA_W'(17'hC000), '0);
        send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'h80);
        apply_settings(CFG_DATA_W'(ALPHA_ONE >> 1), CFG_DATA_W'(2));
        send_sample(8'hFF);
        send_sample(8'h00);
    endtask

    // Random weights, frame sizes and samples; idling schedule changes per third
    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] alpha_value;
        logic [CFG_DATA_W-1:0] frame_value;
        int                    count;
        for (int phase = 0; phase < 24; phase++) begin
            if (phase == 8) begin
                send_idle_pct = 71;
                recv_idle_pct = 22;
            end
            if (phase == 16) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(7))
                0:       alpha_value = '0;
                1:       alpha_value = CFG_DATA_W'(1);
                2:       alpha_value = CFG_DATA_W'(ALPHA_ONE >> 1);
                3:       alpha_value = CFG_DATA_W'(ALPHA_ONE - 1);
                4:       alpha_value = CFG_DATA_W'(ALPHA_ONE);
                5:       alpha_value = CFG_DATA_W'($urandom_range(2 ** CFG_DATA_W - 1));
                default: alpha_value = CFG_DATA_W'($urandom_range(ALPHA_ONE));
            endcase
            case ($urandom_range(9))
                0:       frame_value = '0;
                1:       frame_value = CFG_DATA_W'(1);
                2:       frame_value = CFG_DATA_W'(2);
                3:       frame_value = CFG_DATA_W'(3);
                8:       frame_value = CFG_DATA_W'($urandom_range(written_entries, 33));
                9:       frame_value = CFG_DATA_W'(written_entries);
                default: frame_value = CFG_DATA_W'($urandom_range(32, 4));
            endcase
            apply_settings(alpha_value, frame_value);
            count = $urandom_range(90, 40);
            repeat (count)
                send_sample(random_sample());
        end
    endtask

    // Hold the output off for a long stretch while samples keep coming
    task automatic test_output_backpressure();
        apply_settings(CFG_DATA_W'(17'h4000), CFG_DATA_W'(written_entries));
        stall_hold = 300;
        repeat (80)
            send_sample(random_sample());
    endtask

    // Drive output ready and check every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_diff_item want;
        if (stall_hold > 0) begin
            m_tready   <= 1'b0;
            stall_hold <= stall_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (s_tvalid && !o_s_axis_tready && i_rst_n)
            input_stall_cycles++;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            results_checked++;
            if (expected_diffs.size() == 0) begin
                $display("%0t: unexpected result, difference %0d frame_end %0b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                errors++;
            end else begin
                want = expected_diffs.pop_front();
                if (o_m_axis_tdata !== want.difference) begin
                    $display("%0t: difference mismatch, expected %0d, actual %0d",
                             $time, want.difference, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tlast !== want.frame_end) begin
                    $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                             $time, want.frame_end, o_m_axis_tlast);
                    errors++;
                end
                if (want.frame_end)
                    frame_ends++;
            end
        end
    end

    initial begin
        int waited;
        bg_valid        = 1'b0;
        next_pos        = 0;
        written_entries = 0;
        model_alpha     = '0;
        model_frame     = FRAME_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_frame();
        test_alpha_extremes();
        test_tiny_frames();
        test_random_settings();
        test_output_backpressure();

        // Let the pipeline drain, then watch a little longer for stray results
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_diffs.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_diffs.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_diffs.size());
            errors++;
        end

        $display("Sent %0d samples, checked %0d results with %0d frame ends.",
                 samples_sent, results_checked, frame_ends);
        $display("Saw %0d input stall cycles over %0d store entries in use.",
                 input_stall_cycles, written_entries);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Stop a run that hangs
    initial begin
        #(8 * 400000);
        $display("%0t: run timed out", $time);
        $display("TB_ERROR");
        $finish;
    end

endmodule
